/* rtl/i2crs_pkg.sv */
// Shared types and constants for the I2C register slave.
// Holds the event and bus phase codes and the item structs; no dependencies.
package i2crs_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned ADDR_W = 7;

	// Last data bit of a byte; the ninth bit is the acknowledge slot
	localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [1:0] {
		EV_SCL_RISE = 2'd0,
		EV_SCL_FALL = 2'd1,
		EV_SDA_RISE = 2'd2,
		EV_SDA_FALL = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_PTR   = 3'd2,
		PH_WRITE = 3'd3,
		PH_READ  = 3'd4,
		PH_BUSY  = 3'd5
	} phase_t;

	// One bus edge event as it enters the slave
	typedef struct packed {
		logic              write_ok;
		logic [BYTE_W-1:0] read_data;
		logic              scl_sample;
		logic              sda_sample;
		event_t            mode;
	} event_item_t;

	// One result of an event, packed lowest field last
	typedef struct packed {
		phase_t            bus_phase;
		logic              read_strobe;
		logic [BYTE_W-1:0] write_data;
		logic              write_strobe;
		logic [BYTE_W-1:0] reg_address;
		logic              sda_release;
	} result_item_t;

	localparam int unsigned RESULT_W = $bits(result_item_t);

endpackage

/* rtl/i2crs_core.sv */
// Protocol state of the I2C register slave and its per-event update.
// Depends on i2crs_pkg; the state advances on each accepted event.
module i2crs_core import i2crs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  event_item_t         item,
	input  logic [ADDR_W-1:0]   own_address,
	output result_item_t        result
);

	phase_t             phase_q, phase_n;
	logic [BYTE_W-1:0]  shift_q, shift_n;
	logic [CNT_W-1:0]   bit_cnt_q, bit_cnt_n;
	logic [BYTE_W-1:0]  ptr_q, ptr_n;
	logic               sda_q, sda_n;
	logic [CNT_W-1:0]   bit_cnt_inc;
	logic               wr_strobe;
	logic [BYTE_W-1:0]  wr_data;
	logic               rd_strobe;

	assign bit_cnt_inc = bit_cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};

	// Work out the state after this event
	always_comb begin
		phase_n   = phase_q;
		shift_n   = shift_q;
		bit_cnt_n = bit_cnt_q;
		ptr_n     = ptr_q;
		sda_n     = sda_q;
		wr_strobe = 1'b0;
		wr_data   = '0;
		rd_strobe = 1'b0;
		case (item.mode)
			EV_SCL_RISE: begin
				if (phase_q == PH_ADDR || phase_q == PH_PTR || phase_q == PH_WRITE) begin
					shift_n   = {shift_q[BYTE_W-2:0], item.sda_sample};
					bit_cnt_n = bit_cnt_inc;
				end else if (phase_q == PH_READ) begin
					bit_cnt_n = bit_cnt_inc;
					// master NACK in the acknowledge slot ends the read
					if (bit_cnt_inc > BITS_PER_BYTE && item.sda_sample) begin
						phase_n = PH_BUSY;
					end
				end
			end
			EV_SCL_FALL: begin
				if (bit_cnt_q > BITS_PER_BYTE) begin
					// past the acknowledge slot: start the next byte
					bit_cnt_n = '0;
					if (phase_q == PH_READ) begin
						rd_strobe = 1'b1;
						sda_n     = item.read_data[BYTE_W-1];
						shift_n   = {item.read_data[BYTE_W-2:0], 1'b0};
						ptr_n     = ptr_q + 8'd1;
					end else begin
						sda_n = 1'b1;
					end
				end else begin
					case (phase_q)
						PH_ADDR: begin
							if (bit_cnt_q == BITS_PER_BYTE) begin
								if (shift_q[BYTE_W-1:1] == own_address) begin
									sda_n   = 1'b0;
									phase_n = shift_q[0] ? PH_READ : PH_PTR;
								end else begin
									phase_n = PH_BUSY;
								end
							end
						end
						PH_PTR: begin
							if (bit_cnt_q == BITS_PER_BYTE) begin
								sda_n   = 1'b0;
								ptr_n   = shift_q;
								phase_n = PH_WRITE;
							end
						end
						PH_WRITE: begin
							if (bit_cnt_q == BITS_PER_BYTE) begin
								wr_strobe = 1'b1;
								wr_data   = shift_q;
								ptr_n     = ptr_q + 8'd1;
								if (item.write_ok) begin
									sda_n = 1'b0;
								end else begin
									phase_n = PH_BUSY;
								end
							end
						end
						PH_READ: begin
							if (bit_cnt_q < BITS_PER_BYTE) begin
								sda_n   = shift_q[BYTE_W-1];
								shift_n = {shift_q[BYTE_W-2:0], 1'b0};
							end else begin
								sda_n = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			EV_SDA_RISE: begin
				// stop condition
				if (item.scl_sample) begin
					phase_n = PH_IDLE;
				end
			end
			EV_SDA_FALL: begin
				// start condition
				if (item.scl_sample) begin
					phase_n   = PH_ADDR;
					bit_cnt_n = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Advance the protocol state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			shift_q   <= '0;
			bit_cnt_q <= '0;
			ptr_q     <= '0;
			sda_q     <= 1'b1;
		end else if (step) begin
			phase_q   <= phase_n;
			shift_q   <= shift_n;
			bit_cnt_q <= bit_cnt_n;
			ptr_q     <= ptr_n;
			sda_q     <= sda_n;
		end
	end

	// Report the post-event state
	always_comb begin
		result.sda_release  = sda_n;
		result.reg_address  = ptr_n;
		result.write_strobe = wr_strobe;
		result.write_data   = wr_data;
		result.read_strobe  = rd_strobe;
		result.bus_phase    = phase_n;
	end

endmodule

/* rtl/i2c_register_slave.sv */
// Top level of the I2C register slave: stream ports, address register, result register.
// Depends on i2crs_pkg and i2crs_core.
//
// The slave takes one bus edge event per clock while the output is not stalled and
// returns one result per event through a result register, in the cycle after the
// transfer. The rate is set by the state update in i2crs_core: an event is taken
// whenever the result register is empty or is being drained in the same cycle, so a
// stalled output holds back only the input side. own_address resets to 80; the user
// must write it with cfg_we only while no event is in flight (not enforced here).
module i2c_register_slave import i2crs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [0] sda_sample, [1] scl_sample, [9:2] read_data, [10] write_ok, [15:11] zero
	input  logic [15:0]       s_tdata,
	// [1:0] mode
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [0] sda_release, [8:1] reg_address, [9] write_strobe, [17:10] write_data,
	// [18] read_strobe, [21:19] bus_phase, [23:22] zero
	output logic [23:0]       m_tdata
);

	logic [ADDR_W-1:0]   own_addr_q;
	logic                out_valid_q;
	result_item_t        out_data_q;
	event_item_t         item;
	result_item_t        result;
	logic                in_xfer;

	// Hold the slave address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= 7'd80;
		end else if (cfg_we) begin
			own_addr_q <= cfg_wdata;
		end
	end

	// Unpack the incoming event
	always_comb begin
		item.mode       = event_t'(s_tuser);
		item.sda_sample = s_tdata[0];
		item.scl_sample = s_tdata[1];
		item.read_data  = s_tdata[9:2];
		item.write_ok   = s_tdata[10];
	end

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	i2crs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (in_xfer),
		.item        (item),
		.own_address (own_addr_q),
		.result      (result)
	);

	// Result register: load on an input transfer, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24-RESULT_W){1'b0}}, out_data_q};

	// An input transfer always leaves a result waiting
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> m_tvalid)
		else $error("no result after input transfer");

	// Input only stalls behind a full, stalled result register
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// A single event never both writes and reads the bank
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[9] && m_tdata[18]))
		else $error("write and read strobe in one result");

	// Write data is zero unless a write is offered
	a_wdata_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[9]) |-> (m_tdata[17:10] == 8'd0))
		else $error("write data without write strobe");

endmodule
